### rtl/core/dubd_pkg.sv
package dubd_pkg;

    // Decoder phase for one URI.
    typedef enum logic [1:0] {
        PH_SCAN   = 2'd0,
        PH_DECODE = 2'd1,
        PH_STOP   = 2'd2,
        PH_FAIL   = 2'd3
    } t_phase;

    // Class of one input byte as seen by the decoder.
    typedef enum logic [1:0] {
        CLS_OTHER  = 2'd0,
        CLS_SEXTET = 2'd1,
        CLS_PAD    = 2'd2
    } t_cls;

    // Final status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_MARKER = 2'd1;
    localparam logic [1:0] ST_LIMIT     = 2'd2;

    localparam logic [15:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [2:0]  HEAD_LEN    = 3'd5;
    localparam logic [2:0]  MARKER_LAST = 3'd7;
    localparam logic [7:0]  CHR_SEMI    = 8'h3B;
    localparam logic [7:0]  CHR_PAD     = 8'h3D;

    // One classified byte travelling from the front to the back.
    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        t_cls       cls;
        logic [5:0] sextet;
    } t_item;

    // Characters of the marker ";base64,".
    function automatic logic [7:0] marker_char(input logic [2:0] idx);
        logic [7:0] chr;
        unique case (idx)
            3'd0: chr = 8'h3B;
            3'd1: chr = 8'h62;
            3'd2: chr = 8'h61;
            3'd3: chr = 8'h73;
            3'd4: chr = 8'h65;
            3'd5: chr = 8'h36;
            3'd6: chr = 8'h34;
            default: chr = 8'h2C;
        endcase
        return chr;
    endfunction

    // Base64 alphabet map; bit 6 set means the byte is outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] chr);
        logic [6:0] val;
        if (chr >= 8'h41 && chr <= 8'h5A) begin
            val = 7'(chr - 8'h41);
        end else if (chr >= 8'h61 && chr <= 8'h7A) begin
            val = 7'(chr - 8'h61 + 8'd26);
        end else if (chr >= 8'h30 && chr <= 8'h39) begin
            val = 7'(chr - 8'h30 + 8'd52);
        end else if (chr == 8'h2B) begin
            val = 7'd62;
        end else if (chr == 8'h2F) begin
            val = 7'd63;
        end else begin
            val = 7'd64;
        end
        return val;
    endfunction

endpackage

### rtl/core/dubd_front.sv
module dubd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_end_of_uri,
    output logic           o_item_valid,
    input  logic           i_item_ready,
    output dubd_pkg::t_item o_item
);
    import dubd_pkg::*;

    logic       r_valid;
    t_item      r_item;
    t_item      n_item;
    logic [6:0] w_map;

    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Classify the incoming byte.
    always_comb begin
        w_map         = sextet_of(i_in_byte);
        n_item.raw    = i_in_byte;
        n_item.last   = i_end_of_uri;
        n_item.sextet = w_map[5:0];
        if (i_in_byte == CHR_PAD) begin
            n_item.cls = CLS_PAD;
        end else if (!w_map[6]) begin
            n_item.cls = CLS_SEXTET;
        end else begin
            n_item.cls = CLS_OTHER;
        end
    end

    // Hold the classified byte until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/core/dubd_queue.sv
module dubd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_not_full,
    input  dubd_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_not_empty,
    output dubd_pkg::t_item o_item
);
    import dubd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           w_push;
    logic           w_pop;

    assign o_not_full  = r_count != CW'(DEPTH);
    assign o_not_empty = r_count != '0;
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;
    assign o_item      = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### rtl/core/dubd_back.sv
module dubd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_item_valid,
    output logic            o_pop,
    input  dubd_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_done_res,
    output logic [1:0]      o_status,
    output logic [15:0]     o_byte_count
);
    import dubd_pkg::*;

    logic [15:0] r_limit;
    t_phase      r_phase, n_phase, w_ph_after;
    logic [2:0]  r_mprog, n_mprog;
    logic [2:0]  r_pos, n_pos;
    logic [5:0]  r_left, n_left;
    logic [2:0]  r_lcnt, n_lcnt;
    logic [15:0] r_emit, n_emit;

    logic        r_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_bv;
    logic        r_out_done;
    logic [1:0]  r_out_status, n_out_status;
    logic [15:0] r_out_count;

    logic        w_past_head, w_mk_hit, w_mk_done, w_full, w_lim_hit, w_emit, w_result;
    logic [3:0]  w_sum;
    logic [2:0]  w_n2;
    logic [11:0] w_comb;

    assign o_pop        = i_item_valid && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_done_res   = r_out_done;
    assign o_status     = r_out_status;
    assign o_byte_count = r_out_count;

    // Conditions shared by the phase logic and the datapath.
    always_comb begin
        w_past_head = r_pos >= HEAD_LEN;
        w_mk_hit    = i_item.raw == marker_char(r_mprog);
        w_mk_done   = w_mk_hit && (r_mprog == MARKER_LAST);
        w_sum       = {1'b0, r_lcnt} + 4'd6;
        w_full      = w_sum >= 4'd8;
        w_n2        = 3'(w_sum - 4'd8);
        w_lim_hit   = r_emit >= r_limit;
        w_comb      = {r_left, i_item.sextet};
        w_emit      = o_pop && (r_phase == PH_DECODE) && (i_item.cls == CLS_SEXTET)
                      && w_full && !w_lim_hit;
        w_result    = w_emit || (o_pop && i_item.last);
    end

    // Phase next state; the end of a URI always returns to scanning.
    always_comb begin
        w_ph_after = r_phase;
        unique case (r_phase)
            PH_SCAN: begin
                if (w_past_head && w_mk_done) begin
                    w_ph_after = (r_limit == '0) ? PH_FAIL : PH_DECODE;
                end
            end
            PH_DECODE: begin
                if (i_item.cls == CLS_PAD) begin
                    w_ph_after = PH_STOP;
                end else if (i_item.cls == CLS_SEXTET && w_full && w_lim_hit) begin
                    w_ph_after = PH_FAIL;
                end
            end
            PH_STOP: w_ph_after = PH_STOP;
            PH_FAIL: w_ph_after = PH_FAIL;
            default: w_ph_after = PH_SCAN;
        endcase
        if (!o_pop) begin
            n_phase = r_phase;
        end else if (i_item.last) begin
            n_phase = PH_SCAN;
        end else begin
            n_phase = w_ph_after;
        end
    end

    // Marker tracking, bit accumulation and result fields.
    always_comb begin
        n_mprog      = r_mprog;
        n_pos        = r_pos;
        n_left       = r_left;
        n_lcnt       = r_lcnt;
        n_emit       = r_emit;
        n_out_byte   = 8'd0;
        n_out_status = ST_OK;
        if (o_pop) begin
            if (!w_past_head) begin
                n_pos = r_pos + 1'b1;
            end
            if (r_phase == PH_SCAN && w_past_head) begin
                if (w_mk_done) begin
                    n_mprog = '0;
                end else if (w_mk_hit) begin
                    n_mprog = r_mprog + 1'b1;
                end else begin
                    n_mprog = (i_item.raw == CHR_SEMI) ? 3'd1 : 3'd0;
                end
            end
            if (r_phase == PH_DECODE && i_item.cls == CLS_SEXTET) begin
                if (!w_full) begin
                    n_left = i_item.sextet;
                    n_lcnt = w_sum[2:0];
                end else if (w_emit) begin
                    n_emit = r_emit + 1'b1;
                    n_lcnt = w_n2;
                    case (w_n2)
                        3'd2: begin
                            n_out_byte = w_comb[9:2];
                            n_left     = {4'd0, w_comb[1:0]};
                        end
                        3'd4: begin
                            n_out_byte = w_comb[11:4];
                            n_left     = {2'd0, w_comb[3:0]};
                        end
                        default: begin
                            n_out_byte = w_comb[7:0];
                            n_left     = 6'd0;
                        end
                    endcase
                end
            end
            if (i_item.last) begin
                if (w_ph_after == PH_SCAN) begin
                    n_out_status = ST_NO_MARKER;
                end else if (w_ph_after == PH_FAIL) begin
                    n_out_status = ST_LIMIT;
                end
            end
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Per-URI state, cleared after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCAN;
            r_mprog <= '0;
            r_pos   <= '0;
            r_left  <= '0;
            r_lcnt  <= '0;
            r_emit  <= '0;
        end else begin
            r_phase <= n_phase;
            if (o_pop && i_item.last) begin
                r_mprog <= '0;
                r_pos   <= '0;
                r_left  <= '0;
                r_lcnt  <= '0;
                r_emit  <= '0;
            end else begin
                r_mprog <= n_mprog;
                r_pos   <= n_pos;
                r_left  <= n_left;
                r_lcnt  <= n_lcnt;
                r_emit  <= n_emit;
            end
        end
    end

    // Output register; a result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_out_byte   <= n_out_byte;
            r_out_bv     <= w_emit;
            r_out_done   <= i_item.last;
            r_out_status <= n_out_status;
            r_out_count  <= n_emit;
        end
    end

endmodule

### rtl/core/data_uri_base64_decoder.sv
// Data URI Base64 decoder: one URI byte per transfer, at most one result each.
// A result passes the classify register, a queue entry and the output register before it is offered.
// Throughput: one byte per cycle while no queue is full and the result side is ready,
// set by the decode step in the back.
// Reset: synchronous, active low; clears all URI state and queues, and sets
// the output limit to 65535.
module data_uri_base64_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_uri,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count
);
    import dubd_pkg::*;

    logic  w_f_valid, w_q_not_full, w_q_not_empty, w_pop;
    t_item w_f_item, w_q_item;

    // Front: accept and classify bytes.
    dubd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_end_of_uri (i_end_of_uri),
        .o_item_valid (w_f_valid),
        .i_item_ready (w_q_not_full),
        .o_item       (w_f_item)
    );

    // Queue between the two halves.
    dubd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_f_valid),
        .o_not_full  (w_q_not_full),
        .i_item      (w_f_item),
        .i_pop       (w_pop),
        .o_not_empty (w_q_not_empty),
        .o_item      (w_q_item)
    );

    // Back: marker search, decoding and results.
    dubd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (w_q_not_empty),
        .o_pop        (w_pop),
        .i_item       (w_q_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .o_byte_count (o_byte_count)
    );

    // A result carries a byte, a final status, or both.
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_valid || o_done_res))
        else $error("result with neither byte nor final status");

    // Status is only reported on the final result.
    a_status_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_status == ST_OK))
        else $error("status set on a non-final result");

    // A decoded byte always counts itself.
    a_count_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (o_byte_count != 16'd0))
        else $error("decoded byte with zero count");

    // After a non-final byte, the next byte of the same URI counts one more.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_byte_valid && !o_done_res) ##1
        (o_valid && o_byte_valid && $past(o_valid && i_ready))
        |-> (o_byte_count == $past(o_byte_count) + 16'd1))
        else $error("byte count did not advance by one");

endmodule

### sim/tb_data_uri_base64_decoder.sv
`timescale 1ns / 1ps

module tb_data_uri_base64_decoder;

    import dubd_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int RUN_LIMIT_NS  = 5_000_000;
    localparam int PHASE_BYTES   = 95;
    localparam int NUM_PHASES    = 13;

    localparam logic [63:0] MARKER_TEXT = ";base64,";
    localparam logic [6:0]  NOT_SEXTET  = 7'd64;

    // One decoder result as it should appear on the output channel.
    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } t_decoded;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic [15:0] i_cfg_data   = '0;
    logic        i_valid      = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte    = '0;
    logic        i_end_of_uri = 1'b0;
    logic        o_valid;
    logic        i_ready      = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [15:0] o_byte_count;

    // Decoder state as the testbench predicts it.
    logic [15:0] out_limit   = LIMIT_RESET;
    t_phase      cur_phase   = PH_SCAN;
    logic [3:0]  marker_hits = '0;
    logic [2:0]  head_seen   = '0;
    logic [5:0]  spare_bits  = '0;
    logic [2:0]  spare_count = '0;
    logic [15:0] bytes_out   = '0;

    t_decoded decoded_due [$];
    int       mismatches     = 0;
    int       accepted_bytes = 0;
    int       result_index   = 0;
    logic     steady_flow    = 1'b0;

    data_uri_base64_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_end_of_uri (i_end_of_uri),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_done_res   (o_done_res),
        .o_status     (o_status),
        .o_byte_count (o_byte_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Character number idx of the marker, counted from the semicolon.
    function automatic logic [7:0] marker_byte(input int idx);
        return MARKER_TEXT[63 - 8 * idx -: 8];
    endfunction

    // Value of a Base64 character, or NOT_SEXTET outside the alphabet.
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A]}) return 7'(c - 8'h41);
        if (c inside {[8'h61:8'h7A]}) return 7'(c - 8'h61 + 8'd26);
        if (c inside {[8'h30:8'h39]}) return 7'(c - 8'h30 + 8'd52);
        if (c == 8'h2B) return 7'd62;
        if (c == 8'h2F) return 7'd63;
        return NOT_SEXTET;
    endfunction

    // Base64 character for a six-bit value.
    function automatic logic [7:0] sextet_char(input int v);
        if (v < 26) return 8'(8'h41 + v);
        if (v < 52) return 8'(8'h61 + v - 26);
        if (v < 62) return 8'(8'h30 + v - 52);
        if (v == 62) return 8'h2B;
        return 8'h2F;
    endfunction

    // Advance the predicted decoder by one accepted byte and queue any result.
    function automatic void predict_decode(input logic [7:0] c, input logic last);
        logic        past_head;
        logic        emit;
        logic [7:0]  ob;
        logic [6:0]  v;
        logic [11:0] comb;
        int          n;
        int          p;
        t_decoded    r;
        past_head = (head_seen >= HEAD_LEN);
        emit = 1'b0;
        ob = '0;
        if (!past_head) head_seen = head_seen + 3'd1;

        case (cur_phase)
            PH_SCAN: begin
                if (past_head) begin
                    p = int'(marker_hits[2:0]);
                    if (c == marker_byte(p)) begin
                        if (p == int'(MARKER_LAST)) begin
                            marker_hits = '0;
                            cur_phase = (out_limit == 16'd0) ? PH_FAIL : PH_DECODE;
                        end else begin
                            marker_hits = 4'(p + 1);
                        end
                    end else begin
                        marker_hits = (c == CHR_SEMI) ? 4'd1 : 4'd0;
                    end
                end
            end
            PH_DECODE: begin
                if (c == CHR_PAD) begin
                    cur_phase = PH_STOP;
                end else begin
                    v = b64_value(c);
                    if (v != NOT_SEXTET) begin
                        comb = {spare_bits, v[5:0]};
                        n = int'(spare_count) + 6;
                        if (n >= 8) begin
                            n = n - 8;
                            if (bytes_out >= out_limit) begin
                                cur_phase = PH_FAIL;
                            end else begin
                                ob = 8'(comb >> n);
                                emit = 1'b1;
                                bytes_out = bytes_out + 16'd1;
                                spare_bits = 6'(comb & ((12'd1 << n) - 12'd1));
                                spare_count = 3'(n);
                            end
                        end else begin
                            spare_bits = comb[5:0];
                            spare_count = 3'(n);
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (emit || last) begin
            r.out_byte = ob;
            r.byte_valid = emit;
            r.done_res = last;
            r.status = ST_OK;
            if (last && cur_phase == PH_SCAN) r.status = ST_NO_MARKER;
            if (last && cur_phase == PH_FAIL) r.status = ST_LIMIT;
            r.byte_count = bytes_out;
            decoded_due.push_back(r);
        end

        // The final byte of a URI clears everything but the limit.
        if (last) begin
            cur_phase = PH_SCAN;
            marker_hits = '0;
            head_seen = '0;
            spare_bits = '0;
            spare_count = '0;
            bytes_out = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns, result %0d: %s", $time, result_index, msg);
        mismatches++;
    endtask

    // Offer one URI byte after a random gap and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_uri <= last;
        do @(posedge i_clk); while (!o_ready);
        accepted_bytes++;
        predict_decode(b, last);
    endtask

    task automatic send_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], last_at_end && (i == s.len() - 1));
        end
    endtask

    // Stop offering input and wait until the block has nothing in flight.
    task automatic settle_block();
        i_valid <= 1'b0;
        while (decoded_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_output_limit(input logic [15:0] lim);
        settle_block();
        i_cfg_we <= 1'b1;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        out_limit = lim;
    endtask

    // Random URI: mostly a head, the marker and a Base64 body, sometimes a
    // broken marker or plain noise.
    task automatic send_random_uri();
        logic [7:0] uri [$];
        int         kind;
        int         head_len;
        int         body_len;
        int         cut;
        int         pick;
        kind = $urandom_range(0, 9);
        head_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9);
        repeat (head_len) begin
            uri.push_back(($urandom_range(0, 7) == 0) ? CHR_SEMI : 8'($urandom_range(0, 255)));
        end
        if (kind < 7) begin
            for (int i = 0; i < 8; i++) uri.push_back(marker_byte(i));
        end else if (kind < 9) begin
            cut = $urandom_range(1, 7);
            for (int i = 0; i < cut; i++) uri.push_back(marker_byte(i));
            uri.push_back(8'($urandom_range(0, 255)));
        end
        body_len = $urandom_range(0, 16);
        repeat (body_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                uri.push_back(sextet_char($urandom_range(0, 63)));
            end else if (pick < 87) begin
                case ($urandom_range(0, 3))
                    0: uri.push_back(8'h20);
                    1: uri.push_back(8'h09);
                    2: uri.push_back(8'h0D);
                    default: uri.push_back(8'h0A);
                endcase
            end else if (pick < 96) begin
                uri.push_back(8'($urandom_range(0, 255)));
            end else begin
                uri.push_back(CHR_PAD);
            end
        end
        if (uri.size() == 0) uri.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < uri.size(); i++) send_byte(uri[i], i == uri.size() - 1);
    endtask

    // Marker found late after a false start, whitespace and junk skipped,
    // '=' stopping the decode, and a URI of a single byte.
    task automatic test_marker_and_decode();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text(";bx;;base64,/+ 9z=Q", 1'b1);
        send_text(";", 1'b1);
    endtask

    // A zero limit fails as soon as the marker completes; no marker still
    // reports as not found.
    task automatic test_limit_zero();
        write_output_limit(16'd0);
        send_text("ABCDE;base64,", 1'b1);
        send_text("xx;base64,QQ", 1'b1);
    endtask

    // A new limit written part way through a URI applies to the next byte.
    task automatic test_limit_change_mid_uri();
        write_output_limit(16'hFFFF);
        send_text("abcde;base64,QUJD", 1'b0);
        write_output_limit(16'd3);
        send_text("RA", 1'b1);
    endtask

    // Phases of random URIs, each under its own limit and flow pattern.
    task automatic test_random_streams();
        logic [15:0] lim;
        int          start_count;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 6)
                0: lim = 16'hFFFF;
                1: lim = 16'd0;
                2: lim = 16'd1;
                3: lim = 16'($urandom_range(2, 6));
                4: lim = 16'($urandom_range(7, 65534));
                default: lim = 16'($urandom_range(1, 4));
            endcase
            write_output_limit(lim);
            steady_flow = (ph % 4 == 2);
            start_count = accepted_bytes;
            while (accepted_bytes - start_count < PHASE_BYTES) send_random_uri();
        end
        steady_flow = 1'b0;
    endtask

    // Result side: a random stall before each transfer.
    initial begin : result_sink
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin : check_result
        t_decoded want;
        if (i_rst_n && o_valid && i_ready) begin
            if (decoded_due.size() == 0) begin
                report_mismatch($sformatf("result with none predicted, out_byte %02h",
                                          o_out_byte));
            end else begin
                want = decoded_due.pop_front();
                if (o_out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                              o_out_byte, want.out_byte));
                if (o_byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid %b, predicted %b",
                                              o_byte_valid, want.byte_valid));
                if (o_done_res !== want.done_res)
                    report_mismatch($sformatf("done_res %b, predicted %b",
                                              o_done_res, want.done_res));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              o_status, want.status));
                if (o_byte_count !== want.byte_count)
                    report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                              o_byte_count, want.byte_count));
            end
            result_index++;
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("data_uri_base64_decoder verification failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_marker_and_decode();
        test_limit_zero();
        test_limit_change_mid_uri();
        test_random_streams();
        settle_block();
        if (mismatches == 0) begin
            $display("data_uri_base64_decoder verification clean");
        end else begin
            $display("data_uri_base64_decoder verification failed");
        end
        $finish;
    end

endmodule
